/* design/sensor_sample_fifo_alarm_macros.svh */
// Assertion macros used by the sensor sample monitor checker.
`ifndef SENSOR_SAMPLE_FIFO_ALARM_MACROS_SVH
`define SENSOR_SAMPLE_FIFO_ALARM_MACROS_SVH

// Same-cycle implication on i_clk, disabled while i_rst_n is low.
`define SSFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssfa check failed");

// Next-cycle implication on i_clk, disabled while i_rst_n is low.
`define SSFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssfa check failed");

`endif

/* design/ssfa_pkg.sv */
// Types and constants of the sensor sample monitor.
package ssfa_pkg;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_STATUS = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        STAT_NONE    = 3'd0,
        STAT_ENQ     = 3'd1,
        STAT_DROP    = 3'd2,
        STAT_READ_OK = 3'd3,
        STAT_EMPTY   = 3'd4,
        STAT_REPORT  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CFG_RUN_ENABLE = 2'd0,
        CFG_PERIOD     = 2'd1,
        CFG_THRESHOLD  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0]        seq;
        logic [63:0]        stamp;
        logic signed [31:0] value;
        logic               alarm;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_req;

    localparam logic [15:0]        RAMP_START   = 16'd20000;
    localparam logic [15:0]        RAMP_LIMIT   = 16'd40000;
    localparam logic [15:0]        RAMP_STEP    = 16'd1000;
    localparam logic               RUN_RESET    = 1'b1;
    localparam logic [31:0]        PERIOD_RESET = 32'd1000;
    localparam logic signed [31:0] THRESH_RESET = 32'sd35000;
    localparam int                 ENTRY_W      = $bits(t_entry);

endpackage

/* design/ssfa_ram.sv */
// Generic single-port-write, registered-read RAM.
module ssfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ssfa_fifo.sv */
// Sample FIFO: head/tail pointers and fill count around the sample RAM.
module ssfa_fifo
    import ssfa_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_fifo_req                  i_req,
    input  t_entry                     i_wdata,
    output t_entry                     o_rdata,
    output logic [$clog2(DEPTH+1)-1:0] o_fill,
    output logic                       o_full,
    output logic                       o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_fill, n_fill;
    logic [ENTRY_W-1:0] ram_rdata;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_req.push) begin
            n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_fill = r_fill + 1'b1;
        end
        if (i_req.pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    ssfa_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_req.push),
        .i_waddr(r_tail),
        .i_wdata(i_wdata),
        .i_re   (i_req.pop),
        .i_raddr(r_head),
        .o_rdata(ram_rdata)
    );

    assign o_rdata = t_entry'(ram_rdata);
    assign o_fill  = r_fill;
    assign o_full  = (r_fill == CW'(DEPTH));
    assign o_empty = (r_fill == '0);

endmodule

/* design/sensor_sample_fifo_alarm.sv */
// Top level of the sensor sample monitor: sample generation, counters, result stage.
//
//   channel   direction  handshake                 payload
//   item      in         i_start, o_busy           i_kind, i_sample_value, i_time_now
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_wdata
//   result    out        o_done (one-cycle strobe) o_status .. o_pop_count
//
// An item accepted at one edge shows its result with o_done in the next cycle.
// One item is taken per cycle while o_busy is low; a read's data comes from the sample RAM's registered port.
// o_busy is high for the cycle after reset and low from then on.
// Synchronous active-low reset clears pointers, counters and the result strobe.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module sensor_sample_fifo_alarm
    import ssfa_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_sample_value,
    input  logic [63:0]        i_time_now,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic [63:0]        o_seq,
    output logic [63:0]        o_time_stamp,
    output logic signed [31:0] o_value,
    output logic               o_alarm,
    output logic [6:0]         o_queued,
    output logic [63:0]        o_prod_count,
    output logic [63:0]        o_enq_count,
    output logic [63:0]        o_drop_count,
    output logic [63:0]        o_pop_count
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic               r_busy;
    logic               r_run, n_run;
    logic [31:0]        r_period, n_period;
    logic signed [31:0] r_thresh, n_thresh;
    logic [31:0]        r_tick, n_tick;
    logic [15:0]        r_ramp, n_ramp;
    logic [63:0]        r_seq_next, n_seq_next;
    logic [63:0]        r_produced, n_produced;
    logic [63:0]        r_enq, n_enq;
    logic [63:0]        r_drop, n_drop;
    logic [63:0]        r_popped, n_popped;
    logic [63:0]        r_last_seq, n_last_seq;
    logic signed [31:0] r_last_value, n_last_value;
    logic               r_last_alarm, n_last_alarm;

    logic               r_done, n_done;
    logic               r_from_ram, n_from_ram;
    t_status            r_status, n_status;
    t_entry             r_res, n_res;

    logic               accept;
    t_kind              kind;
    logic [31:0]        tick_inc;
    logic [15:0]        ramp_inc;
    logic               produce;
    logic signed [31:0] prod_value;
    t_entry             new_entry;
    t_fifo_req          fifo_req;
    t_entry             fifo_rdata;
    logic [CW-1:0]      fifo_fill;
    logic               fifo_full;
    logic               fifo_empty;

    assign accept = i_start && !r_busy;
    assign kind   = t_kind'(i_kind);

    always_comb begin
        n_run        = r_run;
        n_period     = r_period;
        n_thresh     = r_thresh;
        n_tick       = r_tick;
        n_ramp       = r_ramp;
        n_seq_next   = r_seq_next;
        n_produced   = r_produced;
        n_enq        = r_enq;
        n_drop       = r_drop;
        n_popped     = r_popped;
        n_last_seq   = r_last_seq;
        n_last_value = r_last_value;
        n_last_alarm = r_last_alarm;
        n_done       = accept;
        n_from_ram   = 1'b0;
        n_status     = STAT_NONE;
        n_res        = '0;
        fifo_req     = '0;
        produce      = 1'b0;

        tick_inc   = r_tick + 32'd1;
        ramp_inc   = r_ramp + RAMP_STEP;
        prod_value = (kind == KIND_WRITE) ? i_sample_value : signed'({16'd0, r_ramp});

        new_entry.seq   = r_seq_next;
        new_entry.stamp = i_time_now;
        new_entry.value = prod_value;
        new_entry.alarm = (prod_value >= r_thresh);

        if (accept) begin
            case (kind)
                KIND_TICK: begin
                    if (r_run) begin
                        if (tick_inc >= r_period) begin
                            n_tick  = '0;
                            produce = 1'b1;
                            n_ramp  = (ramp_inc > RAMP_LIMIT) ? RAMP_START : ramp_inc;
                        end else begin
                            n_tick = tick_inc;
                        end
                    end
                end
                KIND_WRITE: begin
                    produce = 1'b1;
                end
                KIND_READ: begin
                    if (fifo_empty) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        fifo_req.pop = 1'b1;
                        n_from_ram   = 1'b1;
                        n_popped     = r_popped + 64'd1;
                        n_status     = STAT_READ_OK;
                    end
                end
                KIND_STATUS: begin
                    n_status    = STAT_REPORT;
                    n_res.seq   = r_last_seq;
                    n_res.value = r_last_value;
                    n_res.alarm = r_last_alarm;
                end
                default: begin
                    n_status = STAT_NONE;
                end
            endcase
        end

        if (produce) begin
            n_res        = new_entry;
            n_seq_next   = r_seq_next + 64'd1;
            n_produced   = r_produced + 64'd1;
            n_last_seq   = new_entry.seq;
            n_last_value = new_entry.value;
            n_last_alarm = new_entry.alarm;
            if (fifo_full) begin
                n_drop   = r_drop + 64'd1;
                n_status = STAT_DROP;
            end else begin
                fifo_req.push = 1'b1;
                n_enq         = r_enq + 64'd1;
                n_status      = STAT_ENQ;
            end
        end

        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RUN_ENABLE: begin
                    n_run  = i_cfg_wdata[0];
                    n_tick = '0;
                end
                CFG_PERIOD: begin
                    n_period = i_cfg_wdata;
                    n_tick   = '0;
                end
                CFG_THRESHOLD: begin
                    n_thresh = signed'(i_cfg_wdata);
                end
                default: begin
                    n_run = r_run;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_run        <= RUN_RESET;
            r_period     <= PERIOD_RESET;
            r_thresh     <= THRESH_RESET;
            r_tick       <= '0;
            r_ramp       <= RAMP_START;
            r_seq_next   <= 64'd1;
            r_produced   <= '0;
            r_enq        <= '0;
            r_drop       <= '0;
            r_popped     <= '0;
            r_last_seq   <= '0;
            r_last_value <= '0;
            r_last_alarm <= 1'b0;
            r_done       <= 1'b0;
            r_from_ram   <= 1'b0;
        end else begin
            r_busy       <= 1'b0;
            r_run        <= n_run;
            r_period     <= n_period;
            r_thresh     <= n_thresh;
            r_tick       <= n_tick;
            r_ramp       <= n_ramp;
            r_seq_next   <= n_seq_next;
            r_produced   <= n_produced;
            r_enq        <= n_enq;
            r_drop       <= n_drop;
            r_popped     <= n_popped;
            r_last_seq   <= n_last_seq;
            r_last_value <= n_last_value;
            r_last_alarm <= n_last_alarm;
            r_done       <= n_done;
            r_from_ram   <= n_from_ram;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_res    <= n_res;
    end

    ssfa_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (fifo_req),
        .i_wdata(new_entry),
        .o_rdata(fifo_rdata),
        .o_fill (fifo_fill),
        .o_full (fifo_full),
        .o_empty(fifo_empty)
    );

    assign o_busy       = r_busy;
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_seq        = r_from_ram ? fifo_rdata.seq   : r_res.seq;
    assign o_time_stamp = r_from_ram ? fifo_rdata.stamp : r_res.stamp;
    assign o_value      = r_from_ram ? fifo_rdata.value : r_res.value;
    assign o_alarm      = r_from_ram ? fifo_rdata.alarm : r_res.alarm;
    assign o_queued     = 7'(fifo_fill);
    assign o_prod_count = r_produced;
    assign o_enq_count  = r_enq;
    assign o_drop_count = r_drop;
    assign o_pop_count  = r_popped;

endmodule

/* design/ssfa_checker.sv */
// Port-level checker for the sensor sample monitor, bound to the top level.
`include "sensor_sample_fifo_alarm_macros.svh"

module ssfa_checker
    import ssfa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [6:0]  o_queued,
    input logic [63:0] o_enq_count,
    input logic [63:0] o_drop_count
);

    logic item_taken;
    logic empty_seen;
    logic enq_seen;
    logic drop_seen;

    assign item_taken = i_start && !o_busy;
    assign empty_seen = o_done && (o_status == STAT_EMPTY);
    assign enq_seen   = o_done && (o_status == STAT_ENQ);
    assign drop_seen  = o_done && (o_status == STAT_DROP);

    `SSFA_ASSERT_NEXT(a_item_done, item_taken, o_done)
    `SSFA_ASSERT_NOW(a_done_has_item, o_done, $past(item_taken))
    `SSFA_ASSERT_NOW(a_empty_queued, empty_seen, o_queued == 7'd0)
    `SSFA_ASSERT_NOW(a_enq_count, enq_seen, o_enq_count == $past(o_enq_count) + 64'd1)
    `SSFA_ASSERT_NOW(a_drop_count, drop_seen, o_drop_count == $past(o_drop_count) + 64'd1)

endmodule

bind sensor_sample_fifo_alarm ssfa_checker u_ssfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_done      (o_done),
    .o_status    (o_status),
    .o_queued    (o_queued),
    .o_enq_count (o_enq_count),
    .o_drop_count(o_drop_count)
);

/* tb/tb_top.sv */
// Self-checking testbench of the sensor sample monitor against a predictor.
module tb_top;
    import ssfa_pkg::*;

    localparam int         DEPTH      = 64;
    localparam int         N_PHASES   = 6;
    localparam int         PHASE_CMDS = 133;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] value;
        logic [63:0]        now;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [63:0]        seq;
        logic [63:0]        stamp;
        logic signed [31:0] value;
        logic               alarm;
        logic [6:0]         queued;
        logic [63:0]        produced;
        logic [63:0]        enqueued;
        logic [63:0]        dropped;
        logic [63:0]        popped;
    } t_outcome;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_start        = 1'b0;
    logic [1:0]         i_kind         = KIND_TICK;
    logic signed [31:0] i_sample_value = '0;
    logic [63:0]        i_time_now     = '0;
    logic               i_cfg_we       = 1'b0;
    logic [1:0]         i_cfg_index    = CFG_RUN_ENABLE;
    logic [31:0]        i_cfg_wdata    = '0;
    logic               o_busy;
    logic               o_done;
    logic [2:0]         o_status;
    logic [63:0]        o_seq;
    logic [63:0]        o_time_stamp;
    logic signed [31:0] o_value;
    logic               o_alarm;
    logic [6:0]         o_queued;
    logic [63:0]        o_prod_count;
    logic [63:0]        o_enq_count;
    logic [63:0]        o_drop_count;
    logic [63:0]        o_pop_count;

    t_cmd        cmd_q[$];
    t_outcome    outcome_q[$];
    t_cmd        cur_cmd;
    int          items_in_flight = 0;
    int          items_sent      = 0;
    int          errors          = 0;
    int unsigned gap_pct         = 0;

    t_entry             sample_mem [DEPTH];
    t_entry             last_sample = '0;
    int unsigned        head        = 0;
    int unsigned        tail        = 0;
    int unsigned        fill        = 0;
    int unsigned        ticks       = 0;
    logic [31:0]        ramp        = 32'(RAMP_START);
    logic [63:0]        seq_next    = 64'd1;
    logic [63:0]        n_produced  = '0;
    logic [63:0]        n_enqueued  = '0;
    logic [63:0]        n_dropped   = '0;
    logic [63:0]        n_popped    = '0;
    logic               run_en      = RUN_RESET;
    logic [31:0]        period      = PERIOD_RESET;
    logic signed [31:0] threshold   = THRESH_RESET;

    sensor_sample_fifo_alarm #(
        .FIFO_DEPTH(DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_kind        (i_kind),
        .i_sample_value(i_sample_value),
        .i_time_now    (i_time_now),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_seq         (o_seq),
        .o_time_stamp  (o_time_stamp),
        .o_value       (o_value),
        .o_alarm       (o_alarm),
        .o_queued      (o_queued),
        .o_prod_count  (o_prod_count),
        .o_enq_count   (o_enq_count),
        .o_drop_count  (o_drop_count),
        .o_pop_count   (o_pop_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_outcome make_sample(input logic signed [31:0] v, input logic [63:0] now);
        t_outcome o;
        o       = '0;
        o.seq   = seq_next;
        o.stamp = now;
        o.value = v;
        o.alarm = (v >= threshold);
        seq_next   = seq_next + 64'd1;
        n_produced = n_produced + 64'd1;
        last_sample.seq   = o.seq;
        last_sample.value = v;
        last_sample.alarm = o.alarm;
        if (fill >= DEPTH) begin
            n_dropped = n_dropped + 64'd1;
            o.status  = STAT_DROP;
        end else begin
            sample_mem[tail].seq   = o.seq;
            sample_mem[tail].stamp = now;
            sample_mem[tail].value = v;
            sample_mem[tail].alarm = o.alarm;
            tail       = (tail + 1) % DEPTH;
            fill       = fill + 1;
            n_enqueued = n_enqueued + 64'd1;
            o.status   = STAT_ENQ;
        end
        return o;
    endfunction

    function automatic t_outcome next_outcome(input t_cmd c);
        t_outcome o;
        o = '0;
        case (c.kind)
            KIND_TICK: begin
                if (run_en) begin
                    ticks = ticks + 1;
                    if (ticks >= period) begin
                        ticks = 0;
                        o     = make_sample(signed'(ramp), c.now);
                        ramp  = ramp + 32'(RAMP_STEP);
                        if (ramp > RAMP_LIMIT) begin
                            ramp = 32'(RAMP_START);
                        end
                    end
                end
            end
            KIND_WRITE: begin
                o = make_sample(c.value, c.now);
            end
            KIND_READ: begin
                if (fill == 0) begin
                    o.status = STAT_EMPTY;
                end else begin
                    o.seq    = sample_mem[head].seq;
                    o.stamp  = sample_mem[head].stamp;
                    o.value  = sample_mem[head].value;
                    o.alarm  = sample_mem[head].alarm;
                    head     = (head + 1) % DEPTH;
                    fill     = fill - 1;
                    n_popped = n_popped + 64'd1;
                    o.status = STAT_READ_OK;
                end
            end
            default: begin
                o.seq    = last_sample.seq;
                o.value  = last_sample.value;
                o.alarm  = last_sample.alarm;
                o.status = STAT_REPORT;
            end
        endcase
        o.queued   = 7'(fill);
        o.produced = n_produced;
        o.enqueued = n_enqueued;
        o.dropped  = n_dropped;
        o.popped   = n_popped;
        return o;
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_RUN_ENABLE: begin
                run_en = data[0];
                ticks  = 0;
            end
            CFG_PERIOD: begin
                period = data;
                ticks  = 0;
            end
            CFG_THRESHOLD: begin
                threshold = signed'(data);
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return threshold;
            3:       return threshold - 32'sd1;
            4:       return signed'($urandom_range(15000, 45000));
            default: return signed'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic add_cmd(input t_kind k, input logic signed [31:0] v, input logic [63:0] t);
        t_cmd c;
        c.kind  = k;
        c.value = v;
        c.now   = t;
        cmd_q.push_back(c);
        items_in_flight++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : drive
        t_cmd c;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                outcome_q.push_back(next_outcome(cur_cmd));
                items_sent++;
            end
            if (!i_start || !o_busy) begin
                if (cmd_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    c               = cmd_q.pop_front();
                    cur_cmd         = c;
                    i_start        <= 1'b1;
                    i_kind         <= c.kind;
                    i_sample_value <= c.value;
                    i_time_now     <= c.now;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_outcome e;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                $error("result with status %0d arrived with nothing pending", o_status);
                errors++;
            end else begin
                e = outcome_q.pop_front();
                items_in_flight--;
                check_field("status", 64'(e.status), 64'(o_status));
                check_field("seq", e.seq, o_seq);
                check_field("time_stamp", e.stamp, o_time_stamp);
                check_field("value", 64'(unsigned'(e.value)), 64'(unsigned'(o_value)));
                check_field("alarm", 64'(e.alarm), 64'(o_alarm));
                check_field("queued", 64'(e.queued), 64'(o_queued));
                check_field("prod_count", e.produced, o_prod_count);
                check_field("enq_count", e.enqueued, o_enq_count);
                check_field("drop_count", e.dropped, o_drop_count);
                check_field("pop_count", e.popped, o_pop_count);
            end
        end
    end

    initial begin : stimulus
        int unsigned ph_gap [N_PHASES]    = '{0, 57, 17, 57, 0, 17};
        logic        ph_run [N_PHASES]    = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        logic [31:0] ph_period [N_PHASES] = '{32'd0, 32'd1, 32'd3, 32'hFFFF_FFFF,
                                              32'd2, 32'd1};
        logic [31:0] ph_thresh [N_PHASES] = '{32'd35000, 32'h7FFF_FFFF, 32'h8000_0000,
                                              32'd0, 32'd30000, 32'd25000};
        int          added;
        int          len;
        int          burst;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_cmd(KIND_STATUS, '0, rand_time());
        add_cmd(KIND_READ, '0, rand_time());
        add_cmd(KIND_TICK, '0, rand_time());
        add_cmd(KIND_WRITE, 32'sd35000, 64'd1);
        add_cmd(KIND_WRITE, 32'sd34999, 64'd2);
        add_cmd(KIND_WRITE, 32'sh7FFF_FFFF, '1);
        add_cmd(KIND_WRITE, 32'sh8000_0000, '0);
        add_cmd(KIND_WRITE, 32'sh0000_0000, 64'h5555_5555_5555_5555);
        add_cmd(KIND_WRITE, 32'shFFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
        add_cmd(KIND_STATUS, 32'sh7FFF_FFFF, '1);
        for (int i = 0; i < 6; i++) begin
            add_cmd(KIND_READ, signed'($urandom), rand_time());
        end
        add_cmd(KIND_READ, '0, rand_time());
        add_cmd(KIND_STATUS, '0, rand_time());
        add_cmd(KIND_TICK, '0, rand_time());

        for (int p = 0; p < N_PHASES; p++) begin
            wait (items_in_flight == 0);
            repeat (3) @(posedge i_clk);
            if (p == 3) begin
                ph_thresh[p] = $urandom;
            end
            write_reg(CFG_RUN_ENABLE, {31'd0, ph_run[p]});
            write_reg(CFG_PERIOD, ph_period[p]);
            write_reg(CFG_THRESHOLD, ph_thresh[p]);
            if (p == 2) begin
                write_reg(CFG_UNUSED, $urandom);
            end
            gap_pct = ph_gap[p];
            added   = 0;
            while (added < PHASE_CMDS) begin
                burst = $urandom_range(0, 4);
                case (burst)
                    0:       len = $urandom_range(1, 90);
                    1:       len = $urandom_range(1, 80);
                    2:       len = $urandom_range(1, 40);
                    default: len = $urandom_range(1, 20);
                endcase
                for (int i = 0; i < len; i++) begin
                    case (burst)
                        0:       add_cmd(KIND_WRITE, rand_value(), rand_time());
                        1:       add_cmd(KIND_READ, signed'($urandom), rand_time());
                        2:       add_cmd(KIND_TICK, signed'($urandom), rand_time());
                        default: add_cmd(t_kind'($urandom_range(0, 3)), rand_value(),
                                         rand_time());
                    endcase
                end
                added += len;
            end
        end

        wait (items_in_flight == 0);
        repeat (5) @(posedge i_clk);
        $display("Sent %0d items over %0d register settings after a directed start.",
                 items_sent, N_PHASES);
        $display("Samples: %0d produced, %0d stored, %0d dropped full, %0d read back.",
                 n_produced, n_enqueued, n_dropped, n_popped);
        if (errors == 0 && outcome_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
